// File: rtl/whbq_pkg.sv
// whbq_pkg: shared types, codes and defaults for the write hold barrier queue.
// Used by every file in rtl/ through scoped names.
package whbq_pkg;

  localparam int unsigned HoldSlotsDef = 32;
  localparam int unsigned BlkW         = 32;
  localparam int unsigned LenW         = 16;
  localparam int unsigned HdlW         = 16;
  localparam int unsigned CfgDataW     = 32;
  localparam logic [LenW-1:0] BlockBytesRst = 16'd4096;

  typedef enum logic [2:0] {
    REQ_WRITE    = 3'd0,
    REQ_SYNC_BLK = 3'd1,
    REQ_SYNC_ALL = 3'd2,
    REQ_HOLD     = 3'd3,
    REQ_PASS     = 3'd4,
    REQ_RELEASE  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SYNC  = 2'd2,
    ACT_FULL  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_INVALID = 2'd1,
    STS_BUSY    = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_RELEASE = 2'd0,
    MODE_HOLD    = 2'd1,
    MODE_PASS    = 2'd2
  } mode_e;

  typedef enum logic {
    CFG_DEVICE_BLOCKS = 1'b0,
    CFG_BLOCK_BYTES   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
    logic rel_emit;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic is_release;
    logic rel_last;
  } sts_t;

endpackage

// File: rtl/whbq_if.sv
// Request and response channel interfaces of the write hold barrier queue.
// Depends on whbq_pkg for field widths.
interface whbq_req_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 req_type;
  logic [whbq_pkg::BlkW-1:0]  block_number;
  logic [whbq_pkg::LenW-1:0]  block_length;
  logic [whbq_pkg::HdlW-1:0]  data_handle;

  modport source (output valid, req_type, block_number, block_length, data_handle,
                  input ready);
  modport sink   (input valid, req_type, block_number, block_length, data_handle,
                  output ready);
endinterface

interface whbq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [1:0]                 status;
  logic [whbq_pkg::BlkW-1:0]  out_block;
  logic [whbq_pkg::HdlW-1:0]  out_handle;
  logic                       last;

  modport source (output valid, action, status, out_block, out_handle, last,
                  input ready);
  modport sink   (input valid, action, status, out_block, out_handle, last,
                  output ready);
endinterface

// File: rtl/whbq_ctrl.sv
// whbq_ctrl: sequencing state machine (accept, lookup, execute, release walk).
// Depends on whbq_pkg for the command and status structs.
module whbq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output whbq_pkg::cmd_t  cmd_o,
  input  whbq_pkg::sts_t  sts_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_REL  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = sts_i.is_release ? S_REL : S_EXEC;
      end
      S_EXEC: begin
        req_ready_o = !sts_i.out_full;
        if (!sts_i.out_full) begin
          cmd_o.exec = 1'b1;
          if (req_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = S_LOOK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_REL: begin
        if (!sts_i.out_full) begin
          cmd_o.rel_emit = 1'b1;
          if (sts_i.rel_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/whbq_dp.sv
// whbq_dp: config registers, request register, hold table with parallel
// block compare, result logic and output register. Depends on whbq_pkg.
module whbq_dp #(
  parameter int unsigned HOLD_SLOTS = whbq_pkg::HoldSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [whbq_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [2:0]                    req_type_i,
  input  logic [whbq_pkg::BlkW-1:0]     block_number_i,
  input  logic [whbq_pkg::LenW-1:0]     block_length_i,
  input  logic [whbq_pkg::HdlW-1:0]     data_handle_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [1:0]                    action_o,
  output logic [1:0]                    status_o,
  output logic [whbq_pkg::BlkW-1:0]     out_block_o,
  output logic [whbq_pkg::HdlW-1:0]     out_handle_o,
  output logic                          last_o,
  input  whbq_pkg::cmd_t                cmd_i,
  output whbq_pkg::sts_t                sts_o
);

  localparam int unsigned IdxW = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;

  logic [whbq_pkg::BlkW-1:0] dev_blocks_q;
  logic [whbq_pkg::LenW-1:0] blk_bytes_q;

  logic [2:0]                req_type_q;
  logic [whbq_pkg::BlkW-1:0] blk_q;
  logic [whbq_pkg::LenW-1:0] len_q;
  logic [whbq_pkg::HdlW-1:0] hdl_q;

  logic [HOLD_SLOTS-1:0]     hit_d, hit_q;
  logic                      len_ok_q, rng_ok_q;

  whbq_pkg::mode_e           mode_q;
  logic [HOLD_SLOTS-1:0]     valid_q;
  logic [whbq_pkg::BlkW-1:0] slot_blk_q [HOLD_SLOTS];
  logic [whbq_pkg::HdlW-1:0] slot_hdl_q [HOLD_SLOTS];

  logic                      out_vld_q;
  whbq_pkg::action_e         out_act_q;
  whbq_pkg::status_e         out_sts_q;
  logic [whbq_pkg::BlkW-1:0] out_blk_q;
  logic [whbq_pkg::HdlW-1:0] out_hdl_q;
  logic                      out_last_q;

  // lowest free slot and lowest held slot
  logic [HOLD_SLOTS-1:0]     free_oh, used_oh;
  logic [IdxW-1:0]           free_idx, used_idx;
  logic                      any_free, held, rel_last;

  whbq_pkg::action_e         res_act;
  whbq_pkg::status_e         res_sts;
  logic                      res_fwd;
  logic                      res_store;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_blocks_q <= '0;
      blk_bytes_q  <= whbq_pkg::BlockBytesRst;
    end else if (cfg_we_i) begin
      case (whbq_pkg::cfg_idx_e'(cfg_idx_i))
        whbq_pkg::CFG_DEVICE_BLOCKS: dev_blocks_q <= cfg_wdata_i[whbq_pkg::BlkW-1:0];
        whbq_pkg::CFG_BLOCK_BYTES:   blk_bytes_q  <= cfg_wdata_i[whbq_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      blk_q      <= block_number_i;
      len_q      <= block_length_i;
      hdl_q      <= data_handle_i;
    end
  end

  always_comb begin
    for (int i = 0; i < HOLD_SLOTS; i++) begin
      hit_d[i] = valid_q[i] && (slot_blk_q[i] == blk_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q    <= hit_d;
      len_ok_q <= (len_q == blk_bytes_q);
      rng_ok_q <= (blk_q < dev_blocks_q);
    end
  end

  assign free_oh  = ~valid_q & (valid_q + 1'b1);
  assign used_oh  = valid_q & (~valid_q + 1'b1);
  assign any_free = ~&valid_q;
  assign held     = |hit_q;
  assign rel_last = ((valid_q & ~used_oh) == '0);

  always_comb begin
    free_idx = '0;
    used_idx = '0;
    for (int i = 0; i < HOLD_SLOTS; i++) begin
      free_idx = free_idx | (free_oh[i] ? IdxW'(i) : '0);
      used_idx = used_idx | (used_oh[i] ? IdxW'(i) : '0);
    end
  end

  always_comb begin
    res_act   = whbq_pkg::ACT_NONE;
    res_sts   = whbq_pkg::STS_OK;
    res_fwd   = 1'b0;
    res_store = 1'b0;
    case (whbq_pkg::req_e'(req_type_q))
      whbq_pkg::REQ_WRITE: begin
        if (!len_ok_q || !rng_ok_q) begin
          res_sts = whbq_pkg::STS_INVALID;
        end else if (mode_q == whbq_pkg::MODE_HOLD) begin
          if (!held) begin
            if (any_free) begin
              res_store = 1'b1;
            end else begin
              res_sts = whbq_pkg::STS_FULL;
            end
          end
        end else if (!(mode_q == whbq_pkg::MODE_PASS && held)) begin
          res_act = whbq_pkg::ACT_WRITE;
          res_fwd = 1'b1;
        end
      end
      whbq_pkg::REQ_SYNC_BLK: begin
        if (mode_q == whbq_pkg::MODE_HOLD) begin
          res_sts = whbq_pkg::STS_BUSY;
        end else if (!rng_ok_q) begin
          res_sts = whbq_pkg::STS_INVALID;
        end else if (mode_q == whbq_pkg::MODE_PASS && held) begin
          res_sts = whbq_pkg::STS_BUSY;
        end else begin
          res_act = whbq_pkg::ACT_SYNC;
          res_fwd = 1'b1;
        end
      end
      whbq_pkg::REQ_SYNC_ALL: begin
        if (mode_q != whbq_pkg::MODE_RELEASE) begin
          res_sts = whbq_pkg::STS_BUSY;
        end else begin
          res_act = whbq_pkg::ACT_FULL;
        end
      end
      whbq_pkg::REQ_HOLD, whbq_pkg::REQ_PASS, whbq_pkg::REQ_RELEASE: ;
      default: begin
        res_sts = whbq_pkg::STS_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= whbq_pkg::MODE_RELEASE;
      valid_q <= '0;
    end else if (cmd_i.exec) begin
      if (whbq_pkg::req_e'(req_type_q) == whbq_pkg::REQ_HOLD) begin
        mode_q <= whbq_pkg::MODE_HOLD;
      end
      if (whbq_pkg::req_e'(req_type_q) == whbq_pkg::REQ_PASS) begin
        mode_q <= whbq_pkg::MODE_PASS;
      end
      if (res_store) begin
        valid_q <= valid_q | free_oh;
      end
    end else if (cmd_i.rel_emit) begin
      valid_q <= valid_q & ~used_oh;
      if (rel_last) begin
        mode_q <= whbq_pkg::MODE_RELEASE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && res_store) begin
      slot_blk_q[free_idx] <= blk_q;
      slot_hdl_q[free_idx] <= hdl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.rel_emit) begin
      out_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_act_q  <= res_act;
      out_sts_q  <= res_sts;
      out_blk_q  <= res_fwd ? blk_q : '0;
      out_hdl_q  <= res_fwd ? hdl_q : '0;
      out_last_q <= 1'b1;
    end else if (cmd_i.rel_emit) begin
      out_act_q  <= (valid_q != '0) ? whbq_pkg::ACT_WRITE : whbq_pkg::ACT_NONE;
      out_sts_q  <= whbq_pkg::STS_OK;
      out_blk_q  <= (valid_q != '0) ? slot_blk_q[used_idx] : '0;
      out_hdl_q  <= (valid_q != '0) ? slot_hdl_q[used_idx] : '0;
      out_last_q <= rel_last;
    end
  end

  assign rsp_valid_o  = out_vld_q;
  assign action_o     = out_act_q;
  assign status_o     = out_sts_q;
  assign out_block_o  = out_blk_q;
  assign out_handle_o = out_hdl_q;
  assign last_o       = out_last_q;

  assign sts_o.out_full   = out_vld_q;
  assign sts_o.is_release = (whbq_pkg::req_e'(req_type_q) == whbq_pkg::REQ_RELEASE);
  assign sts_o.rel_last   = rel_last;

endmodule

// File: rtl/write_hold_barrier_queue.sv
// write_hold_barrier_queue: top level, controller plus datapath.
// Depends on whbq_pkg, whbq_if, whbq_ctrl and whbq_dp.
//
//   port    | dir | handshake       | word
//   --------+-----+-----------------+------------------------------------------
//   req_i   | in  | valid/ready     | req_type, block_number, block_length, handle
//   rsp_o   | out | valid/ready     | action, status, out_block, out_handle, last
//   cfg_*_i | in  | write enable    | register index, write data
//
// Each non-release word passes a compare step (the parallel slot compare and
// range/length check), then a decide step: update the table and load the output.
// Release passes the lookup step, then loads held slots one at a time (lowest first,
// one no-action word if none is held): the output register must empty in between.
// A stalled output register holds the decide and release steps; a new word is
// accepted while a result waits only when the controller is idle.
// Reset clears the mode and valid bits at once.
module write_hold_barrier_queue #(
  parameter int unsigned HOLD_SLOTS = whbq_pkg::HoldSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [whbq_pkg::CfgDataW-1:0] cfg_wdata_i,
  whbq_req_if.sink                      req_i,
  whbq_rsp_if.source                    rsp_o
);

  whbq_pkg::cmd_t cmd;
  whbq_pkg::sts_t sts;

  whbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  whbq_dp #(
    .HOLD_SLOTS (HOLD_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_i.req_type),
    .block_number_i (req_i.block_number),
    .block_length_i (req_i.block_length),
    .data_handle_i  (req_i.data_handle),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .action_o       (rsp_o.action),
    .status_o       (rsp_o.status),
    .out_block_o    (rsp_o.out_block),
    .out_handle_o   (rsp_o.out_handle),
    .last_o         (rsp_o.last),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// File: rtl/whbq_checker.sv
// whbq_checker: port-level assertions on the response channel, bound to the top.
// Depends on whbq_pkg for action and status codes.
module whbq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [1:0]                action_i,
  input logic [1:0]                status_i,
  input logic [whbq_pkg::BlkW-1:0] out_block_i,
  input logic [whbq_pkg::HdlW-1:0] out_handle_i,
  input logic                      last_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(action_i) && $stable(out_block_i)
      && $stable(last_i))
    else $error("response word changed while stalled");

  a_err_no_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != whbq_pkg::STS_OK |-> action_i == whbq_pkg::ACT_NONE)
    else $error("error status on a forwarded word");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (action_i == whbq_pkg::ACT_NONE || action_i == whbq_pkg::ACT_FULL)
      |-> out_block_i == '0 && out_handle_i == '0)
    else $error("nonzero block or handle without a block forward");

  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && action_i == whbq_pkg::ACT_FULL |-> last_i && status_i == whbq_pkg::STS_OK)
    else $error("full sync not a single ok word");

endmodule

bind write_hold_barrier_queue whbq_checker u_whbq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .action_i     (rsp_o.action),
  .status_i     (rsp_o.status),
  .out_block_i  (rsp_o.out_block),
  .out_handle_i (rsp_o.out_handle),
  .last_i       (rsp_o.last)
);
